FILE: rtl/core/stlb_pkg.sv
// stlb_pkg: payload types, register indexes and reset values for the
// light-balance controller of the sun tracker. No dependencies.
package stlb_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DUTY_W   = 10;
  localparam int BURST_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DZ_VERT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_HORIZ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_DUTY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_BURST = 2'd3;

  localparam logic [SAMPLE_W-1:0] DZ_VERT_RST    = 10'd200;
  localparam logic [SAMPLE_W-1:0] DZ_HORIZ_RST   = 10'd200;
  localparam logic [DUTY_W-1:0]   DRIVE_DUTY_RST = 10'd500;
  localparam logic [BURST_W-1:0]  STEP_BURST_RST = 16'd200;
  localparam logic [DUTY_W-1:0]   DUTY_MAX       = 10'd1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] north_sample;
    logic [SAMPLE_W-1:0] east_sample;
    logic [SAMPLE_W-1:0] west_sample;
    logic [SAMPLE_W-1:0] south_sample;
  } sample_t;

  typedef struct packed {
    logic                step_request;
    logic                step_dir;
    logic [BURST_W-1:0]  step_pulses;
    logic [DUTY_W-1:0]   east_duty;
    logic [DUTY_W-1:0]   west_duty;
    logic [SAMPLE_W-1:0] north_avg;
    logic [SAMPLE_W-1:0] east_avg;
    logic [SAMPLE_W-1:0] west_avg;
    logic [SAMPLE_W-1:0] south_avg;
  } result_t;

endpackage

FILE: rtl/core/sun_tracker_light_balance.sv
// sun_tracker_light_balance: four-channel moving average with a shared
// serial divider, followed by the step and duty decision.
// Depends on stlb_pkg.
//
//   channel  | direction | handshake                  | payload
//   sample   | in        | sample_valid/sample_stall  | sample_t
//   result   | out       | result_valid/result_stall  | result_t
//   cfg      | in        | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// After its transfer, each item runs per channel one window memory access and
// one sum update, then SAMPLE_BITS steps of the single restoring divider per
// channel average.
// sample_stall is high for the whole item, and longer if the result register
// is still held by result_stall. Synchronous reset clears the sums, fill count
// and write slot; the window memory is never cleared.
module sun_tracker_light_balance
  import stlb_pkg::*;
#(
  parameter int WINDOW      = 64,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CW     = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SB + CW;
  localparam int QC_W   = $clog2(SB);
  localparam int CMP_W  = (SB > SAMPLE_W) ? SB : SAMPLE_W;
  localparam int DEPTH  = 4 * (2 ** SLOT_W);
  localparam logic [CW-1:0] WIN_C = CW'(WINDOW);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MEM  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] dz_vert;
  logic [SAMPLE_W-1:0] dz_horiz;
  logic [DUTY_W-1:0]   drive_duty;
  logic [BURST_W-1:0]  step_burst;

  logic [CW-1:0]     fill_count;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] item_slot;
  logic              item_full;
  logic [1:0]        chan;
  logic [SB-1:0]     xs [4];
  logic [SUM_W-1:0]  sums [4];
  logic [SB-1:0]     avg [4];

  logic [SB-1:0]     win_mem [DEPTH];
  logic [SB-1:0]     old_sample;
  logic [$clog2(DEPTH)-1:0] mem_addr;

  logic [CW-1:0]   rem;
  logic [SB-1:0]   dq;
  logic [QC_W-1:0] cnt;
  logic [CW:0]     trial;
  logic            ge;
  logic [CW-1:0]   rem_next;
  logic [SB-1:0]   dq_next;

  logic [CW-1:0] slot_inc;
  logic          accept;
  result_t       res_next;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign mem_addr     = {chan, item_slot};
  assign slot_inc     = CW'(write_slot) + CW'(1);

  // restoring divider step
  always_comb begin
    trial = {rem, dq[SB-1]};
    ge    = (trial >= {1'b0, fill_count});
    if (ge) begin
      rem_next = CW'(trial - {1'b0, fill_count});
    end else begin
      rem_next = trial[CW-1:0];
    end
    dq_next = {dq[SB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_vert    <= DZ_VERT_RST;
      dz_horiz   <= DZ_HORIZ_RST;
      drive_duty <= DRIVE_DUTY_RST;
      step_burst <= STEP_BURST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DZ_VERT:    dz_vert    <= cfg_data[SAMPLE_W-1:0];
        CFG_DZ_HORIZ:   dz_horiz   <= cfg_data[SAMPLE_W-1:0];
        CFG_DRIVE_DUTY: drive_duty <= cfg_data[DUTY_W-1:0];
        CFG_STEP_BURST: step_burst <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MEM) begin
      old_sample        <= win_mem[mem_addr];
      win_mem[mem_addr] <= xs[chan];
    end
  end

  always_comb begin
    logic [CMP_W-1:0] n, e, w, s, dv, dh;
    logic [DUTY_W-1:0] duty;
    logic step_req;
    n = CMP_W'(avg[0]);
    e = CMP_W'(avg[1]);
    w = CMP_W'(avg[2]);
    s = CMP_W'(avg[3]);
    dv = (n > s) ? n - s : s - n;
    dh = (e > w) ? e - w : w - e;
    duty = (drive_duty > DUTY_MAX) ? DUTY_MAX : drive_duty;
    step_req = (dv > CMP_W'(dz_vert));
    res_next.step_request = step_req;
    res_next.step_dir     = !(n > s);
    res_next.step_pulses  = step_req ? step_burst : '0;
    res_next.east_duty    = ((dh > CMP_W'(dz_horiz)) && (e > w)) ? duty : '0;
    res_next.west_duty    = ((dh > CMP_W'(dz_horiz)) && !(e > w)) ? duty : '0;
    res_next.north_avg    = SAMPLE_W'(avg[0]);
    res_next.east_avg     = SAMPLE_W'(avg[1]);
    res_next.west_avg     = SAMPLE_W'(avg[2]);
    res_next.south_avg    = SAMPLE_W'(avg[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      write_slot   <= '0;
      chan         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            xs[0]     <= SB'(sample.north_sample);
            xs[1]     <= SB'(sample.east_sample);
            xs[2]     <= SB'(sample.west_sample);
            xs[3]     <= SB'(sample.south_sample);
            item_slot <= write_slot;
            item_full <= (fill_count >= WIN_C);
            if (fill_count < WIN_C) begin
              fill_count <= fill_count + CW'(1);
            end
            write_slot <= (slot_inc >= WIN_C) ? '0 : SLOT_W'(slot_inc);
            chan  <= '0;
            state <= ST_MEM;
          end
        end
        ST_MEM: state <= ST_SUM;
        ST_SUM: begin
          sums[chan] <= sums[chan] - (item_full ? SUM_W'(old_sample) : '0)
                        + SUM_W'(xs[chan]);
          chan  <= chan + 2'd1;
          state <= (chan == 2'd3) ? ST_LOAD : ST_MEM;
        end
        ST_LOAD: begin
          rem   <= sums[chan][SUM_W-1:SB];
          dq    <= sums[chan][SB-1:0];
          cnt   <= QC_W'(SB - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= rem_next;
          dq  <= dq_next;
          cnt <= cnt - QC_W'(1);
          if (cnt == '0) begin
            avg[chan] <= dq_next;
            chan      <= chan + 2'd1;
            state     <= (chan == 2'd3) ? ST_DONE : ST_LOAD;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= res_next;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= WIN_C)
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(write_slot) < WIN_C)
    else $error("write slot beyond window");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < fill_count))
    else $error("divider remainder not below divisor");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MEM) && (chan == 2'd0) && (fill_count != '0))
    else $error("item did not start at first channel");

endmodule

FILE: dv/tb.sv
// tb: self-checking testbench for sun_tracker_light_balance. Predicts every
// result from its own copy of the moving-average windows and control registers.
// Depends on stlb_pkg and the block under test; nothing else.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stlb_pkg::*;

  localparam int WIN_DEPTH      = 64;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int REPORT_MAX     = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DZ_VERT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [SAMPLE_W-1:0] win_mem [4][WIN_DEPTH];
  logic [BURST_W-1:0]  win_sum [4] = '{default: '0};
  logic [6:0]          fill_cnt = '0;
  logic [5:0]          wr_slot = '0;
  logic [SAMPLE_W-1:0] dz_vert = DZ_VERT_RST;
  logic [SAMPLE_W-1:0] dz_horiz = DZ_HORIZ_RST;
  logic [DUTY_W-1:0]   duty_reg = DRIVE_DUTY_RST;
  logic [BURST_W-1:0]  burst_reg = STEP_BURST_RST;

  result_t predicted_results [$];
  result_t want;
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      quiet_run = 1'b0;

  sun_tracker_light_balance i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic result_t light_balance(input sample_t s);
    logic [SAMPLE_W-1:0] x [4];
    int                  avg [4];
    int                  duty;
    int                  ns_diff;
    int                  ew_diff;
    bit                  full;
    result_t             r;
    x[0] = s.north_sample;
    x[1] = s.east_sample;
    x[2] = s.west_sample;
    x[3] = s.south_sample;
    full = (fill_cnt >= WIN_DEPTH);
    for (int c = 0; c < 4; c++) begin
      if (full) win_sum[c] -= win_mem[c][wr_slot];
      win_mem[c][wr_slot] = x[c];
      win_sum[c] += x[c];
    end
    wr_slot = (wr_slot == WIN_DEPTH - 1) ? '0 : wr_slot + 1'b1;
    if (!full) fill_cnt++;
    for (int c = 0; c < 4; c++) avg[c] = int'(win_sum[c]) / int'(fill_cnt);
    duty = (duty_reg > DUTY_MAX) ? int'(DUTY_MAX) : int'(duty_reg);
    ns_diff = (avg[0] > avg[3]) ? avg[0] - avg[3] : avg[3] - avg[0];
    ew_diff = (avg[1] > avg[2]) ? avg[1] - avg[2] : avg[2] - avg[1];
    r = '0;
    r.step_request = (ns_diff > int'(dz_vert));
    r.step_dir     = !(avg[0] > avg[3]);
    r.step_pulses  = r.step_request ? burst_reg : '0;
    if (ew_diff > int'(dz_horiz)) begin
      if (avg[1] > avg[2]) r.east_duty = DUTY_W'(duty);
      else r.west_duty = DUTY_W'(duty);
    end
    r.north_avg = SAMPLE_W'(avg[0]);
    r.east_avg  = SAMPLE_W'(avg[1]);
    r.west_avg  = SAMPLE_W'(avg[2]);
    r.south_avg = SAMPLE_W'(avg[3]);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rail();
    return $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
  endfunction

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    if (!quiet_run && $urandom_range(99) < 30) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predicted_results.insert(predicted_results.size(), light_balance(s));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    if (idx == CFG_STEP_BURST) word = CFG_DATA_W'(value);
    else word[SAMPLE_W-1:0] = SAMPLE_W'(value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= word;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DZ_VERT: dz_vert = word[SAMPLE_W-1:0];
      CFG_DZ_HORIZ: dz_horiz = word[SAMPLE_W-1:0];
      CFG_DRIVE_DUTY: duty_reg = word[DUTY_W-1:0];
      CFG_STEP_BURST: burst_reg = word[BURST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_controls(input int dzv, input int dzh, input int duty, input int burst);
    write_reg(CFG_DZ_VERT, dzv);
    write_reg(CFG_DZ_HORIZ, dzh);
    write_reg(CFG_DRIVE_DUTY, duty);
    write_reg(CFG_STEP_BURST, burst);
  endtask

  // reset controls; first two transfers sit exactly on and just past the dead zones
  task automatic test_reset_values();
    send_sample('{10'd700, 10'd300, 10'd500, 10'd500});
    send_sample('{10'd702, 10'd300, 10'd502, 10'd500});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd1023, 10'd1023, 10'd1023, 10'd1023});
    send_sample('{10'd1023, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd1023, 10'd0, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd1023});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd1023});
    send_sample('{10'd0, 10'd0, 10'd0, 10'd1023});
    send_sample('{10'd0, 10'd1023, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd1023, 10'd0, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd1023, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd1023, 10'd0});
    send_sample('{10'd0, 10'd0, 10'd1023, 10'd0});
    send_sample('{10'd512, 10'd512, 10'd512, 10'd512});
    wait_results_drained();
  endtask

  // zero and full-scale dead zones, saturating duty, burst extremes
  task automatic test_register_extremes();
    int      dz_set [3];
    int      duty_set [3];
    int      burst_set [3];
    sample_t s;
    dz_set    = '{0, 1023, 1};
    duty_set  = '{1023, 0, 1000};
    burst_set = '{65535, 0, 1};
    for (int k = 0; k < 3; k++) begin
      set_controls(dz_set[k], dz_set[k], duty_set[k], burst_set[k]);
      for (int i = 0; i < 10; i++) begin
        if (i < 5) s = '{rail(), rail(), rail(), rail()};
        else s = sample_t'({$urandom, $urandom});
        send_sample(s);
      end
      wait_results_drained();
    end
  endtask

  // clustered light levels per channel, shifting now and then, with noise
  task automatic test_random_phases();
    int      centre [4];
    int      spread [4];
    int      n_items;
    int      dz_top;
    sample_t s;
    for (int p = 0; p < 12; p++) begin
      quiet_run = (p == 6);
      dz_top = (p % 4 == 0) ? 1023 : 250;
      set_controls($urandom_range(0, dz_top), $urandom_range(0, dz_top),
                   $urandom_range(0, 1023), $urandom);
      for (int c = 0; c < 4; c++) begin
        centre[c] = $urandom_range(0, SAMPLE_MAX);
        spread[c] = ($urandom_range(3) == 0) ? 512 : $urandom_range(0, 120);
      end
      n_items = $urandom_range(60, 76);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(99) < 4) centre[$urandom_range(3)] = $urandom_range(0, SAMPLE_MAX);
        if ($urandom_range(99) < 15) s = sample_t'({$urandom, $urandom});
        else s = '{near(centre[0], spread[0]), near(centre[1], spread[1]),
                   near(centre[2], spread[2]), near(centre[3], spread[3])};
        send_sample(s);
        if ($urandom_range(99) < 3) wait_results_drained();
      end
      wait_results_drained();
    end
    quiet_run = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [BURST_W-1:0] exp_v,
                             input logic [BURST_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, got_v);
    end
  endtask

  always @(negedge clk) begin
    result_stall <= !quiet_run && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result transfer with nothing predicted", $realtime);
      end else begin
        want = predicted_results[0];
        predicted_results.delete(0);
        check_field("step_request", BURST_W'(want.step_request),
                    BURST_W'(result.step_request));
        check_field("step_dir", BURST_W'(want.step_dir), BURST_W'(result.step_dir));
        check_field("step_pulses", want.step_pulses, result.step_pulses);
        check_field("east_duty", BURST_W'(want.east_duty), BURST_W'(result.east_duty));
        check_field("west_duty", BURST_W'(want.west_duty), BURST_W'(result.west_duty));
        check_field("north_avg", BURST_W'(want.north_avg), BURST_W'(result.north_avg));
        check_field("east_avg", BURST_W'(want.east_avg), BURST_W'(result.east_avg));
        check_field("west_avg", BURST_W'(want.west_avg), BURST_W'(result.west_avg));
        check_field("south_avg", BURST_W'(want.south_avg), BURST_W'(result.south_avg));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_register_extremes();
    test_random_phases();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/stlb_pkg.sv
rtl/core/sun_tracker_light_balance.sv
dv/tb.sv
